FILE: rtl/core/uigf_pkg.sv
`timescale 1ns / 1ps

package uigf_pkg;

	// field and register widths
	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int EL_W    = 16;
	localparam int GAP_W   = 32;
	localparam int CNT_W   = 7;
	localparam int QT_W    = GAP_W + 1;
	localparam int CFG_A_W = 1;

	localparam int STORE_DEPTH_DEF = 64;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

	// register indexes
	localparam logic [CFG_A_W-1:0] REG_GAP_US    = 1'b0;
	localparam logic [CFG_A_W-1:0] REG_BUF_LIMIT = 1'b1;

	localparam logic [GAP_W-1:0] GAP_US_RST    = 32'd1000;
	localparam logic [CNT_W-1:0] BUF_LIMIT_RST = 7'd64;

	typedef struct packed {
		logic accept;
		logic start_dump;
	} cmd_t;

	typedef struct packed {
		logic emit_req;
		logic issued_all;
	} sts_t;

endpackage

FILE: rtl/core/uart_idle_gap_framer.sv
`timescale 1ns / 1ps
// event in: one request a cycle while idle
// frame out: registered read-out starts on the closing request, one byte a cycle unless output stalls
// input held off while an n-byte frame is read out of the store, longer under output stalls
// reset: tracking cleared, gap 1000 us, limit 64; the frame store itself is not cleared

module uart_idle_gap_framer #(
	parameter int STORE_DEPTH = uigf_pkg::STORE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration writes
	input  logic                          cfg_we,
	input  logic [uigf_pkg::CFG_A_W-1:0]  cfg_addr,
	input  logic [uigf_pkg::GAP_W-1:0]    cfg_wdata,

	// receive events
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,   // rx_byte[7:0], tick_us[23:8]
	input  logic [uigf_pkg::KIND_W-1:0]   s_axis_tuser,   // kind[1:0]

	// frame bytes
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,   // frame_byte[7:0], frame_length[14:8], zero[15]
	output logic                          m_axis_tlast    // last
);

	localparam int AW = $clog2(STORE_DEPTH);

	uigf_pkg::cmd_t cmd;
	uigf_pkg::sts_t sts;

	logic                        emit_req;
	logic [uigf_pkg::CNT_W-1:0]  emit_len;
	logic                        issued_all;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [uigf_pkg::BYTE_W-1:0] wr_data;
	logic [uigf_pkg::BYTE_W-1:0] out_byte;
	logic [uigf_pkg::CNT_W-1:0]  out_len;

	assign sts.emit_req   = emit_req;
	assign sts.issued_all = issued_all;

	// sequencer: idle takes events, dump holds them off while the store is read
	uigf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// counters, quiet-time tracking and frame-end decision
	uigf_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.kind       (s_axis_tuser),
		.rx_byte    (s_axis_tdata[7:0]),
		.tick_us    (s_axis_tdata[23:8]),
		.cmd        (cmd),
		.emit_req   (emit_req),
		.emit_len   (emit_len),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// byte store with its read-out counter and output register
	uigf_frame_buf #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.cmd        (cmd),
		.emit_len   (emit_len),
		.issued_all (issued_all),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.out_len    (out_len),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_len, out_byte};

	// a frame is never started empty
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_dump |-> (emit_len != '0))
		else $error("frame dump started with no bytes");

	// starting a dump blocks new events on the next cycle
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_dump |=> !s_axis_tready)
		else $error("event request taken right after a dump started");

	// no event taken while stored bytes are still unread
	a_no_accept_mid_dump: assert property (@(posedge clk) disable iff (!arst_n)
		!issued_all |-> !s_axis_tready)
		else $error("event request taken during frame read-out");

	// an output byte always carries a valid frame length
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[14:8] != '0))
		else $error("frame byte with zero length");

endmodule

FILE: rtl/core/uigf_ctrl.sv
`timescale 1ns / 1ps

module uigf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  uigf_pkg::sts_t sts,
	output uigf_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic state_q;

	assign in_ready       = (state_q == ST_IDLE);
	assign cmd.accept     = in_valid && in_ready;
	assign cmd.start_dump = cmd.accept && sts.emit_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_dump) begin
						state_q <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					// every byte read out, last one may still wait at the output
					if (sts.issued_all) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/uigf_dp.sv
`timescale 1ns / 1ps

module uigf_dp #(
	parameter int STORE_DEPTH = uigf_pkg::STORE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [uigf_pkg::CFG_A_W-1:0]      cfg_addr,
	input  logic [uigf_pkg::GAP_W-1:0]        cfg_wdata,
	input  logic [uigf_pkg::KIND_W-1:0]       kind,
	input  logic [uigf_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [uigf_pkg::EL_W-1:0]         tick_us,
	input  uigf_pkg::cmd_t                    cmd,
	output logic                              emit_req,
	output logic [uigf_pkg::CNT_W-1:0]        emit_len,
	output logic                              wr_en,
	output logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
	output logic [uigf_pkg::BYTE_W-1:0]       wr_data
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [uigf_pkg::CNT_W-1:0] DEPTH_C = uigf_pkg::CNT_W'(STORE_DEPTH);

	logic [uigf_pkg::GAP_W-1:0] gap_q;
	logic [uigf_pkg::CNT_W-1:0] buf_limit_q;
	logic [uigf_pkg::CNT_W-1:0] byte_count_q;
	logic [uigf_pkg::CNT_W-1:0] seen_count_q;
	logic                       line_active_q;
	logic [uigf_pkg::QT_W-1:0]  quiet_q;

	logic [uigf_pkg::CNT_W-1:0] lim;
	logic [uigf_pkg::CNT_W-1:0] n;
	logic [uigf_pkg::QT_W-1:0]  quiet_sum;
	logic                       tick_live;
	logic                       gap_hit;
	logic                       room;

	always_comb begin
		lim       = (buf_limit_q > DEPTH_C) ? DEPTH_C : buf_limit_q;
		n         = (byte_count_q > lim) ? lim : byte_count_q;
		room      = (n < lim);
		tick_live = (tick_us != '0);
		quiet_sum = quiet_q + uigf_pkg::QT_W'(tick_us);
		gap_hit   = line_active_q && (n == seen_count_q)
		            && (quiet_sum >= uigf_pkg::QT_W'(gap_q));
	end

	always_comb begin
		case (kind)
			uigf_pkg::KIND_TICK:    emit_req = tick_live && (n != '0) && gap_hit;
			uigf_pkg::KIND_TIMEOUT: emit_req = (n != '0);
			default:                emit_req = 1'b0;
		endcase
	end

	assign emit_len = n;
	assign wr_en    = cmd.accept && (kind == uigf_pkg::KIND_BYTE) && room;
	assign wr_addr  = n[AW-1:0];
	assign wr_data  = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= uigf_pkg::GAP_US_RST;
			buf_limit_q <= uigf_pkg::BUF_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				uigf_pkg::REG_GAP_US:    gap_q       <= cfg_wdata;
				uigf_pkg::REG_BUF_LIMIT: buf_limit_q <= cfg_wdata[uigf_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			seen_count_q  <= '0;
			line_active_q <= 1'b0;
			quiet_q       <= '0;
		end else if (cmd.accept) begin
			if (emit_req) begin
				// frame goes out, tracking starts afresh
				byte_count_q  <= '0;
				seen_count_q  <= '0;
				line_active_q <= 1'b0;
				quiet_q       <= '0;
			end else begin
				case (kind)
					uigf_pkg::KIND_BYTE: begin
						byte_count_q <= room ? n + 1'b1 : n;
					end
					uigf_pkg::KIND_TICK: begin
						if (tick_live) begin
							byte_count_q <= n;
							if (n == '0) begin
								seen_count_q  <= '0;
								line_active_q <= 1'b0;
								quiet_q       <= '0;
							end else if (n != seen_count_q) begin
								seen_count_q  <= n;
								line_active_q <= 1'b1;
								quiet_q       <= '0;
							end else if (line_active_q) begin
								quiet_q <= quiet_sum;
							end
						end
					end
					uigf_pkg::KIND_TIMEOUT: begin
						byte_count_q <= n;
					end
					default: begin
						// line error drops the frame
						byte_count_q  <= '0;
						seen_count_q  <= '0;
						line_active_q <= 1'b0;
						quiet_q       <= '0;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/uigf_frame_buf.sv
`timescale 1ns / 1ps

module uigf_frame_buf #(
	parameter int STORE_DEPTH = uigf_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
	input  logic [uigf_pkg::BYTE_W-1:0]    wr_data,
	input  uigf_pkg::cmd_t                 cmd,
	input  logic [uigf_pkg::CNT_W-1:0]     emit_len,
	output logic                           issued_all,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [uigf_pkg::BYTE_W-1:0]    out_byte,
	output logic [uigf_pkg::CNT_W-1:0]     out_len,
	output logic                           out_last
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic [uigf_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

	logic [uigf_pkg::CNT_W-1:0]  len_q;
	logic [uigf_pkg::CNT_W-1:0]  rd_idx_q;
	logic                        out_valid_q;
	logic                        out_last_q;
	logic [uigf_pkg::CNT_W-1:0]  out_len_q;
	logic [uigf_pkg::BYTE_W-1:0] rd_data_q;
	logic                        rd_en;

	assign issued_all = (rd_idx_q == len_q);
	// read only when the output slot is empty or being emptied
	assign rd_en      = !issued_all && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx_q[AW-1:0]];
			out_len_q <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cmd.start_dump) begin
				len_q    <= emit_len;
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rd_en) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (rd_idx_q + 1'b1 == len_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = rd_data_q;
	assign out_len   = out_len_q;
	assign out_last  = out_last_q;

endmodule

FILE: tb/tb_uart_idle_gap_framer.sv
`timescale 1ns / 1ps

module tb_uart_idle_gap_framer;

	localparam int DEPTH = 64;

	// clock and reset
	logic clk;
	logic arst_n = 1'b0;

	// configuration port, idle from the start
	logic                          cfg_we    = 1'b0;
	logic [uigf_pkg::CFG_A_W-1:0]  cfg_addr  = uigf_pkg::REG_GAP_US;
	logic [uigf_pkg::GAP_W-1:0]    cfg_wdata = '0;

	// event side
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [23:0]                   s_axis_tdata  = '0;   // rx_byte[7:0], tick_us[23:8]
	logic [uigf_pkg::KIND_W-1:0]   s_axis_tuser  = uigf_pkg::KIND_BYTE;   // kind[1:0]

	// frame side
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [15:0]         m_axis_tdata;   // frame_byte[7:0], frame_length[14:8], zero[15]
	logic                m_axis_tlast;   // last

	uart_idle_gap_framer #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// one frame byte as it should leave the block
	typedef struct packed {
		logic [uigf_pkg::BYTE_W-1:0] data;
		logic [uigf_pkg::CNT_W-1:0]  length;
		logic                        last;
	} frame_beat_t;

	frame_beat_t beats_due[$];

	// shadow of the framer: registers and tracking state, reset values at start
	logic [uigf_pkg::GAP_W-1:0]  gap_set     = uigf_pkg::GAP_US_RST;
	logic [uigf_pkg::CNT_W-1:0]  limit_set   = uigf_pkg::BUF_LIMIT_RST;
	logic [uigf_pkg::BYTE_W-1:0] stored[DEPTH];
	int                          stored_count  = 0;
	int                          count_at_tick = 0;
	logic                        line_busy     = 1'b0;
	logic [uigf_pkg::QT_W-1:0]   quiet_us      = '0;

	int  errors     = 0;
	int  items_sent = 0;
	// when set, neither side idles
	bit  calm       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// ---------------------------------------------------------------
	// frame prediction
	// ---------------------------------------------------------------

	// limits above the store depth fall back to the depth
	function automatic int limit_in_use();
		return (int'(limit_set) > DEPTH) ? DEPTH : int'(limit_set);
	endfunction

	// a lowered limit trims the stored count when it is next read
	function automatic int trimmed_count();
		if (stored_count > limit_in_use())
			stored_count = limit_in_use();
		return stored_count;
	endfunction

	function automatic void clear_line();
		stored_count  = 0;
		count_at_tick = 0;
		line_busy     = 1'b0;
		quiet_us      = '0;
	endfunction

	// queue the whole frame, then drop all tracking; an empty frame changes nothing
	function automatic void close_frame(input int n);
		frame_beat_t beat;
		if (n == 0)
			return;
		for (int k = 0; k < n; k++) begin
			beat.data   = stored[k];
			beat.length = uigf_pkg::CNT_W'(n);
			beat.last   = (k + 1 == n);
			beats_due.push_back(beat);
		end
		clear_line();
	endfunction

	// one accepted request moves the shadow on
	function automatic void track_event(input logic [uigf_pkg::KIND_W-1:0] kind,
			input logic [uigf_pkg::BYTE_W-1:0] rx_val,
			input logic [uigf_pkg::EL_W-1:0] el);
		int n;
		case (kind)
			uigf_pkg::KIND_BYTE: begin
				n = trimmed_count();
				if (n < limit_in_use()) begin
					stored[n]    = rx_val;
					stored_count = n + 1;
				end
			end
			uigf_pkg::KIND_TICK: begin
				// a tick with nothing elapsed leaves everything alone
				if (el != 0) begin
					n = trimmed_count();
					if (n == 0) begin
						clear_line();
					end else if (n != count_at_tick) begin
						// new bytes since the last tick: line busy, quiet time restarts
						count_at_tick = n;
						line_busy     = 1'b1;
						quiet_us      = '0;
					end else if (line_busy) begin
						quiet_us = quiet_us + uigf_pkg::QT_W'(el);
						if (quiet_us >= {1'b0, gap_set})
							close_frame(n);
					end
				end
			end
			uigf_pkg::KIND_TIMEOUT: begin
				// timeout on an empty store does nothing
				close_frame(trimmed_count());
			end
			default: begin
				// line error throws the frame away
				clear_line();
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// receiver back-pressure: ready dropped at random with a chance of about 15 percent, never when calm
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 15);

	// one request on the event side; valid is left high after acceptance so
	// that a back-to-back request does not lower and raise it in one step
	task automatic send_event(input logic [uigf_pkg::KIND_W-1:0] kind,
			input logic [uigf_pkg::BYTE_W-1:0] rx_val,
			input logic [uigf_pkg::EL_W-1:0] el);
		while (!calm && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {el, rx_val};
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		track_event(kind, rx_val, el);
		items_sent++;
	endtask

	// sender stops until every predicted byte is out, then lets the dump finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// both registers, gap first and then limit, only with the block idle
	task automatic write_config(input logic [uigf_pkg::GAP_W-1:0] gap,
			input logic [uigf_pkg::CNT_W-1:0] lim);
		settle();
		cfg_we    <= 1'b1;
		cfg_addr  <= uigf_pkg::REG_GAP_US;
		cfg_wdata <= gap;
		@(posedge clk);
		gap_set = gap;
		cfg_addr  <= uigf_pkg::REG_BUF_LIMIT;
		cfg_wdata <= uigf_pkg::GAP_W'(lim);
		@(posedge clk);
		limit_set = lim;
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// frame checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (beats_due.size() == 0) begin
				report_mismatch($sformatf("unexpected frame byte %02h", m_axis_tdata[7:0]));
			end else begin
				want = beats_due.pop_front();
				if (m_axis_tdata[7:0] !== want.data)
					report_mismatch($sformatf("frame_byte %02h, want %02h",
						m_axis_tdata[7:0], want.data));
				if (m_axis_tdata[14:8] !== want.length)
					report_mismatch($sformatf("frame_length %0d, want %0d",
						m_axis_tdata[14:8], want.length));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
			end
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset values: gap 1000, limit 64, frame closed by quiet time
	task automatic test_default_gap();
		send_event(uigf_pkg::KIND_BYTE, 8'h00, 16'h0000);
		send_event(uigf_pkg::KIND_BYTE, 8'hFF, 16'hFFFF);
		send_event(uigf_pkg::KIND_BYTE, 8'hA5, 16'h0000);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd0);     // nothing elapsed, no effect
		send_event(uigf_pkg::KIND_TICK, 8'hFF, 16'd7);     // count changed, line goes busy
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd999);   // one short of the gap
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd1);     // gap reached exactly
	endtask

	task automatic test_timeout_and_error();
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);   // empty store, ignored
		send_event(uigf_pkg::KIND_ERROR, 8'h00, 16'h0000);     // empty store, just clears
		send_event(uigf_pkg::KIND_BYTE, 8'h12, 16'h0000);
		send_event(uigf_pkg::KIND_BYTE, 8'h34, 16'h0000);
		send_event(uigf_pkg::KIND_ERROR, 8'h00, 16'h0000);     // frame discarded
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd10);        // nothing stored
		send_event(uigf_pkg::KIND_BYTE, 8'h5A, 16'h0000);
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);   // one-byte frame
	endtask

	task automatic test_buffer_limits();
		// single byte store, later bytes dropped
		write_config(32'd1000, 7'd1);
		send_event(uigf_pkg::KIND_BYTE, 8'h81, 16'h0000);
		send_event(uigf_pkg::KIND_BYTE, 8'h82, 16'h0000);
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);
		// zero limit: nothing is ever stored
		write_config(32'd1000, 7'd0);
		send_event(uigf_pkg::KIND_BYTE, 8'h99, 16'h0000);
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);
		// limit beyond depth, then lowered with bytes already stored
		write_config(32'd1000, 7'd127);
		send_event(uigf_pkg::KIND_BYTE, 8'h01, 16'h0000);
		send_event(uigf_pkg::KIND_BYTE, 8'h02, 16'h0000);
		send_event(uigf_pkg::KIND_BYTE, 8'h03, 16'h0000);
		write_config(32'd1000, 7'd2);
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);
	endtask

	task automatic test_gap_extremes();
		// zero gap: first quiet tick with time elapsed ends it
		write_config(32'd0, 7'd64);
		send_event(uigf_pkg::KIND_BYTE, 8'h3C, 16'h0000);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd3);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd1);
		// widest gap: quiet time grows without end, timeout closes
		write_config(32'hFFFF_FFFF, 7'd64);
		send_event(uigf_pkg::KIND_BYTE, 8'hC3, 16'h0000);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'd1);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'hFFFF);
		send_event(uigf_pkg::KIND_TICK, 8'h00, 16'hFFFF);
		send_event(uigf_pkg::KIND_TIMEOUT, 8'h00, 16'h0000);
	endtask

	// mostly small steps, now and then any value, rarely zero
	function automatic logic [uigf_pkg::EL_W-1:0] pick_elapsed();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		else if (roll < 25)
			return uigf_pkg::EL_W'($urandom_range(65535));
		return uigf_pkg::EL_W'($urandom_range(1, 400));
	endfunction

	function automatic logic [uigf_pkg::BYTE_W-1:0] any_byte();
		return uigf_pkg::BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic [uigf_pkg::EL_W-1:0] any_elapsed();
		return uigf_pkg::EL_W'($urandom_range(65535));
	endfunction

	// a burst of bytes, some ticks, then mostly a close by gap, timeout or error
	task automatic send_sequence();
		int nbytes;
		int roll;
		nbytes = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
		for (int k = 0; k < nbytes; k++) begin
			send_event(uigf_pkg::KIND_BYTE, any_byte(), any_elapsed());
			if ($urandom_range(3) == 0)
				send_event(uigf_pkg::KIND_TICK, any_byte(), pick_elapsed());
		end
		// noise in the middle of a frame
		if ($urandom_range(9) == 0)
			send_event(uigf_pkg::KIND_W'($urandom_range(3)), any_byte(), any_elapsed());
		roll = $urandom_range(99);
		if (roll < 60) begin
			repeat ($urandom_range(1, 6))
				send_event(uigf_pkg::KIND_TICK, any_byte(), pick_elapsed());
			if ($urandom_range(1) == 0)
				send_event(uigf_pkg::KIND_TIMEOUT, any_byte(), any_elapsed());
		end else if (roll < 85) begin
			send_event(uigf_pkg::KIND_TIMEOUT, any_byte(), any_elapsed());
		end else if (roll < 95) begin
			send_event(uigf_pkg::KIND_ERROR, any_byte(), any_elapsed());
		end
		// otherwise the frame carries over into the next burst
	endtask

	task automatic test_random_traffic();
		int first;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_config(uigf_pkg::GAP_W'($urandom_range(1, 400)),
					uigf_pkg::CNT_W'($urandom_range(1, 64)));
				1: write_config(32'd1, 7'd1);
				2: write_config(32'hFFFF_FFFF, 7'd64);
				3: write_config(32'd0, 7'd2);
				4: write_config($urandom, uigf_pkg::CNT_W'($urandom_range(65, 127)));
				default: write_config(uigf_pkg::GAP_W'($urandom_range(1, 2000)),
					uigf_pkg::CNT_W'($urandom_range(1, 64)));
			endcase
			// one phase runs flat out on both sides
			calm  = (phase == 5);
			first = items_sent;
			while (items_sent - first < 30)
				send_sequence();
		end
		settle();
		calm = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_gap();
		test_timeout_and_error();
		test_buffer_limits();
		test_gap_extremes();
		test_random_traffic();
		settle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/uigf_pkg.sv
rtl/core/uigf_ctrl.sv
rtl/core/uigf_dp.sv
rtl/core/uigf_frame_buf.sv
rtl/core/uart_idle_gap_framer.sv
tb/tb_uart_idle_gap_framer.sv
